@@ hw/rtl/ptdt_pkg.sv @@
// Package for the per-task deadline timer: task count, widths, command codes,
// controller state type and the controller-to-datapath command struct.
// No dependencies.
`default_nettype none

package ptdt_pkg;

    // Number of task channels
    localparam int NUM_TASKS = 16;
    // Address width of the deadline store and the scan counter
    localparam int ADDR_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int DL_W = 64;
    localparam int WORD_W = 32;
    localparam int MASK_W = 16;
    localparam logic [WORD_W-1:0] NO_COMPARE = {WORD_W{1'b1}};

    // Command codes
    localparam logic [1:0] CMD_ARM = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_PROCESS = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } ptdt_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              load;
        logic              scan_rd;
        logic [ADDR_W-1:0] scan_addr;
        logic              commit;
    } ptdt_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/ptdt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ptdt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ptdt_ctrl.sv @@
// Controller of the deadline timer: sequences accept, deadline scan,
// result commit and the output valid flag.
// Depends on ptdt_pkg.
`default_nettype none

module ptdt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         cmd,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ptdt_pkg::ptdt_cmd_t     dp_cmd,
    output ptdt_pkg::ptdt_state_t   state
);

    ptdt_pkg::ptdt_state_t             state_reg, state_next;
    logic [ptdt_pkg::ADDR_W-1:0]       cnt_reg, cnt_next;
    logic                              out_valid_reg, out_valid_next;
    logic                              commit;
    logic                              scan_last;

    assign scan_last = (cnt_reg == ptdt_pkg::ADDR_W'(ptdt_pkg::NUM_TASKS - 1));
    assign commit = (state_reg == ptdt_pkg::ST_FINISH) && (!out_valid_reg || out_ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptdt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (cmd == ptdt_pkg::CMD_PROCESS) ? ptdt_pkg::ST_SCAN
                                                                : ptdt_pkg::ST_FINISH;
                end
            end
            ptdt_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ptdt_pkg::ST_DRAIN;
                end
            end
            ptdt_pkg::ST_DRAIN:
            begin
                state_next = ptdt_pkg::ST_FINISH;
            end
            ptdt_pkg::ST_FINISH:
            begin
                if (commit)
                begin
                    state_next = ptdt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptdt_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and counter/valid next values
    always_comb
    begin
        in_ready = (state_reg == ptdt_pkg::ST_IDLE);
        dp_cmd.load = in_valid && (state_reg == ptdt_pkg::ST_IDLE);
        dp_cmd.scan_rd = (state_reg == ptdt_pkg::ST_SCAN);
        dp_cmd.scan_addr = cnt_reg;
        dp_cmd.commit = commit;

        cnt_next = cnt_reg;
        if (state_reg == ptdt_pkg::ST_IDLE)
        begin
            cnt_next = '0;
        end
        else if (state_reg == ptdt_pkg::ST_SCAN)
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptdt_pkg::ST_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign state = state_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ptdt_dp.sv @@
// Datapath of the deadline timer: command latch, running bits, deadline
// store, scan evaluation, compare register and result registers.
// Depends on ptdt_pkg and ptdt_ram.
`default_nettype none

module ptdt_dp (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire ptdt_pkg::ptdt_cmd_t              dp_cmd,
    input  wire logic [1:0]                       cmd,
    input  wire logic [3:0]                       task_req,
    input  wire logic [ptdt_pkg::DL_W-1:0]        deadline,
    input  wire logic [ptdt_pkg::DL_W-1:0]        now,
    output logic                                  status,
    output logic                                  raise_now,
    output logic [ptdt_pkg::MASK_W-1:0]           expired_mask,
    output logic [ptdt_pkg::WORD_W-1:0]           compare_value,
    output logic                                  compare_enabled
);

    localparam int AW = ptdt_pkg::ADDR_W;
    localparam int NT = ptdt_pkg::NUM_TASKS;
    localparam int WW = ptdt_pkg::WORD_W;
    localparam int MW = ptdt_pkg::MASK_W;

    // Latched transaction
    logic [1:0]                  cmd_reg;
    logic [3:0]                  task_reg;
    logic [ptdt_pkg::DL_W-1:0]   dl_reg;
    logic [ptdt_pkg::DL_W-1:0]   now_reg;

    // Timer state
    logic [NT-1:0]               running_reg, running_next;
    logic [WW-1:0]               cmp_reg, cmp_next;

    // Scan state
    logic                        eval_valid_reg;
    logic [AW-1:0]               eval_idx_reg;
    logic [NT-1:0]               expired_reg, expired_next;
    logic [WW-1:0]               best_reg, best_next;
    logic                        found_reg, found_next;

    // Result registers
    logic                        status_reg, status_next;
    logic                        raise_reg, raise_next;
    logic [MW-1:0]               mask_reg, mask_next;
    logic [WW-1:0]               cval_reg, cval_next;
    logic                        cen_reg, cen_next;

    logic [ptdt_pkg::DL_W-1:0]   rd_data;
    logic                        ram_we;
    logic [AW-1:0]               task_addr;
    logic                        task_ok;
    logic [WW-1:0]               dl_hi, dl_lo, now_hi, rd_hi, rd_lo;

    assign task_addr = AW'(task_reg);
    assign task_ok = (int'(task_reg) < NT);
    assign dl_hi = dl_reg[ptdt_pkg::DL_W-1:WW];
    assign dl_lo = dl_reg[WW-1:0];
    assign now_hi = now_reg[ptdt_pkg::DL_W-1:WW];
    assign rd_hi = rd_data[ptdt_pkg::DL_W-1:WW];
    assign rd_lo = rd_data[WW-1:0];

    ptdt_ram #(
        .WIDTH (ptdt_pkg::DL_W),
        .DEPTH (NT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (task_addr),
        .wdata (dl_reg),
        .raddr (dp_cmd.scan_addr),
        .rdata (rd_data)
    );

    // Latch the transaction payload
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            cmd_reg <= cmd;
            task_reg <= task_req;
            dl_reg <= deadline;
            now_reg <= now;
        end
    end

    // Evaluate one scanned entry per cycle
    always_comb
    begin
        expired_next = expired_reg;
        best_next = best_reg;
        found_next = found_reg;
        if (dp_cmd.load)
        begin
            expired_next = '0;
            best_next = ptdt_pkg::NO_COMPARE;
            found_next = 1'b0;
        end
        else if (eval_valid_reg && running_reg[eval_idx_reg])
        begin
            if (rd_data <= now_reg)
            begin
                expired_next[eval_idx_reg] = 1'b1;
            end
            else if (rd_hi == now_hi && (!found_reg || rd_lo < best_reg))
            begin
                best_next = rd_lo;
                found_next = 1'b1;
            end
        end
    end

    // Commit the command and build the result
    always_comb
    begin
        running_next = running_reg;
        cmp_next = cmp_reg;
        ram_we = 1'b0;
        status_next = status_reg;
        raise_next = raise_reg;
        mask_next = mask_reg;
        cval_next = cval_reg;
        cen_next = cen_reg;
        if (dp_cmd.commit)
        begin
            status_next = 1'b0;
            raise_next = 1'b0;
            mask_next = '0;
            cval_next = '0;
            cen_next = 1'b0;
            unique case (cmd_reg)
                ptdt_pkg::CMD_ARM:
                begin
                    if (!task_ok || running_reg[task_addr])
                    begin
                        status_next = 1'b1;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                        running_next[task_addr] = 1'b1;
                        raise_next = (dl_hi < now_hi) || (dl_hi == now_hi && dl_lo <= cmp_reg);
                    end
                end
                ptdt_pkg::CMD_CANCEL:
                begin
                    if (task_ok)
                    begin
                        running_next[task_addr] = 1'b0;
                    end
                end
                ptdt_pkg::CMD_PROCESS:
                begin
                    running_next = running_reg & ~expired_reg;
                    cmp_next = found_reg ? best_reg : ptdt_pkg::NO_COMPARE;
                    for (int i = 0; i < MW; i++)
                    begin
                        mask_next[i] = (i < NT) ? expired_reg[i % NT] : 1'b0;
                    end
                    cval_next = found_reg ? best_reg : ptdt_pkg::NO_COMPARE;
                    cen_next = found_reg;
                end
                default:
                begin
                    // Unused code: no state change, all fields zero
                end
            endcase
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= '0;
            cmp_reg <= ptdt_pkg::NO_COMPARE;
            eval_valid_reg <= 1'b0;
            eval_idx_reg <= '0;
        end
        else
        begin
            running_reg <= running_next;
            cmp_reg <= cmp_next;
            eval_valid_reg <= dp_cmd.scan_rd;
            eval_idx_reg <= dp_cmd.scan_addr;
        end
    end

    // Hold scan and result payload
    always_ff @(posedge clk)
    begin
        expired_reg <= expired_next;
        best_reg <= best_next;
        found_reg <= found_next;
        status_reg <= status_next;
        raise_reg <= raise_next;
        mask_reg <= mask_next;
        cval_reg <= cval_next;
        cen_reg <= cen_next;
    end

    assign status = status_reg;
    assign raise_now = raise_reg;
    assign expired_mask = mask_reg;
    assign compare_value = cval_reg;
    assign compare_enabled = cen_reg;

endmodule

`default_nettype wire

@@ hw/rtl/per_task_deadline_timer_core.sv @@
// Per-task deadline timer. Arm and cancel go from accept straight to the finish state.
// Process first scans the deadline store one entry per cycle through its single
// read port, then drains the last read before the finish state.
// One transaction in flight; a new one is taken while a result waits on the output.
// Reset clears running bits, sets the compare register to all ones (disabled),
// and empties the output; the deadline store is not cleared.
`default_nettype none

module per_task_deadline_timer_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        cmd,
    input  wire logic [3:0]                        task_req,
    input  wire logic [ptdt_pkg::DL_W-1:0]         deadline,
    input  wire logic [ptdt_pkg::DL_W-1:0]         now,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   status,
    output logic                                   raise_now,
    output logic [ptdt_pkg::MASK_W-1:0]            expired_mask,
    output logic [ptdt_pkg::WORD_W-1:0]            compare_value,
    output logic                                   compare_enabled
);

    ptdt_pkg::ptdt_cmd_t   dp_cmd;
    ptdt_pkg::ptdt_state_t state;

    ptdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_cmd    (dp_cmd),
        .state     (state)
    );

    ptdt_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .dp_cmd          (dp_cmd),
        .cmd             (cmd),
        .task_req        (task_req),
        .deadline        (deadline),
        .now             (now),
        .status          (status),
        .raise_now       (raise_now),
        .expired_mask    (expired_mask),
        .compare_value   (compare_value),
        .compare_enabled (compare_enabled)
    );

    // A disabled compare reports either the all-ones value or zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !compare_enabled) |-> (compare_value == ptdt_pkg::NO_COMPARE)
                                            || (compare_value == '0))
        else $error("compare_value inconsistent with compare_enabled");

    // Arm results never carry process fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status || raise_now)) |-> (expired_mask == '0 && !compare_enabled))
        else $error("arm result carries process fields");

    // Busy arm never asks for immediate processing
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> !raise_now)
        else $error("busy arm with raise_now");

    // A process transaction is not finished in the cycle after accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && cmd == ptdt_pkg::CMD_PROCESS)
            |=> (state == ptdt_pkg::ST_SCAN))
        else $error("process transaction skipped the scan");

endmodule

`default_nettype wire
